/* sv/motion_trail_point_buffer_top_macros.svh */
// ----------------------------------------------------------------------------
// Motion trail point buffer assertion macros
// Shared property wrappers for the checker; clocked on clk.
// ----------------------------------------------------------------------------
`ifndef MOTION_TRAIL_POINT_BUFFER_TOP_MACROS_SVH
`define MOTION_TRAIL_POINT_BUFFER_TOP_MACROS_SVH

// Property checked outside reset only.
`define MTPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked during reset as well.
`define MTPB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/mtpb_pkg.sv */
// ----------------------------------------------------------------------------
// Motion trail point buffer package
// Word types, codes and shared constants.
// ----------------------------------------------------------------------------
package mtpb_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int CNT_W          = 7;
  localparam int IDX_W          = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_TOO_CLOSE = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 3'd0,
    CFG_MIN_DIST = 3'd1,
    CFG_DURATION = 3'd2,
    CFG_FADE     = 3'd3,
    CFG_ALPHA    = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_PUSH_WR,
    S_TICK,
    S_ALPHA_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0]        elapsed;
    logic [IDX_W-1:0]   point_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CNT_W-1:0]   point_count;
    logic [CNT_W-1:0]   removed;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        out_age;
    logic [7:0]         out_alpha;
  } out_word_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] age;
  } entry_t;

endpackage

/* sv/mtpb_stream_if.sv */
// ----------------------------------------------------------------------------
// Motion trail point buffer stream channel
// Valid/ready channel carrying one word of type word_t.
// ----------------------------------------------------------------------------
interface mtpb_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/mtpb_alpha_div.sv */
// ----------------------------------------------------------------------------
// Alpha divider
// Restoring divider, one quotient bit a cycle, eight-bit quotient.
// ----------------------------------------------------------------------------
module mtpb_alpha_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [39:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [7:0]  quot
);
  logic [39:0] rem_r, rem_nxt;
  logic [39:0] dvs_r, dvs_nxt;
  logic [7:0]  quo_r, quo_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dvs_nxt  = {1'b0, den, 7'b0};
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // subtract where the shifted divisor fits
      if (rem_r >= dvs_r) begin
        rem_nxt = rem_r - dvs_r;
        quo_nxt = {quo_r[6:0], 1'b1};
      end else begin
        quo_nxt = {quo_r[6:0], 1'b0};
      end
      dvs_nxt = dvs_r >> 1;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
endmodule

/* sv/motion_trail_point_buffer_top.sv */
// ----------------------------------------------------------------------------
// Motion trail point buffer
// Bounded oldest-to-newest trail of Q16.16 points with saturating ages.
// ----------------------------------------------------------------------------
// One word in, one word out. The trail lives in a ring memory of MAX_POINTS
// entries with one read and one write port; a single 32x32 multiplier and a
// small sequencer do the arithmetic, so the block takes one word at a time and
// drops ready until that word's result sits in the output register. A push
// with the spacing check sends three squared deltas and the squared limit
// through the shared multiplier; a read with fading runs eight divider steps;
// a tick sweeps the ring, reading, ageing and writing back one entry a cycle.
// A finished result may wait in the output register while the next word is
// taken. Configuration is written on cfg_we at register indexes 0 to 4; other
// indexes are ignored, and a capacity write trims the trail at once.
// Entries are never cleared: only entries written since reset are read.
module motion_trail_point_buffer_top #(
  parameter int MAX_POINTS = mtpb_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mtpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtpb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  mtpb_stream_if.sink                     in_ch,
  mtpb_stream_if.source                   out_ch
);
  import mtpb_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = AW + 1;

  // ring slot arithmetic: base + offset, wrapped once
  function automatic logic [AW-1:0] slot_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(MAX_POINTS)) s = s - SW'(MAX_POINTS);
    return s[AW-1:0];
  endfunction

  // capacity clamped to [2, MAX_POINTS]
  function automatic logic [CW-1:0] eff_of(logic [CNT_W-1:0] c);
    logic [CW-1:0] e;
    if (c < CNT_W'(2)) e = CW'(2);
    else if (32'(c) > 32'(MAX_POINTS)) e = CW'(MAX_POINTS);
    else e = CW'(c);
    return e;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // state and configuration
  state_t          state_r, state_nxt;
  logic [CW-1:0]   held_r, held_nxt;
  logic [AW-1:0]   oldest_r, oldest_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [30:0]     mind_r, mind_nxt;
  logic [31:0]     dur_r, dur_nxt;
  logic            fade_r, fade_nxt;
  logic [7:0]      alpha_r, alpha_nxt;

  // working registers
  in_word_t        item_r, item_nxt;
  out_word_t       res_r, res_nxt;
  out_word_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      mcnt_r, mcnt_nxt;
  logic [63:0]     prod_r, prod_nxt;
  logic [63:0]     acc_r, acc_nxt;
  logic [CW-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [AW-1:0]   rd_slot_r, rd_slot_nxt;
  logic [AW-1:0]   wr_slot_r, wr_slot_nxt;
  logic            pend_r, pend_nxt;
  logic [CW-1:0]   exp_r, exp_nxt;

  // ring memory
  entry_t          mem [MAX_POINTS];
  entry_t          rd_r;
  logic            mem_re, mem_we;
  logic [AW-1:0]   mem_raddr, mem_waddr;
  entry_t          mem_wdata;

  // shared multiplier
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;
  logic [31:0]     pa_c, pb_c;
  logic signed [32:0] dif_c, neg_c;
  logic [31:0]     mag_c;

  // push eviction
  logic [CW-1:0]   eff_c, ev_c, held_tmp_c;
  logic [AW-1:0]   oldest_tmp_c;

  // tick ageing
  logic [32:0]     age_sum_c;
  logic [31:0]     age_new_c;
  logic [31:0]     left_c;

  logic            div_start, div_done;
  logic [7:0]      div_quot;
  logic [CW-1:0]   cfg_eff_c;

  assign mul_p = mul_a * mul_b;

  // select the coordinate pair (or the spacing limit) for this step
  always_comb begin
    case (mcnt_r)
      2'd0:    begin pa_c = item_r.coord_x; pb_c = rd_r.x; end
      2'd1:    begin pa_c = item_r.coord_y; pb_c = rd_r.y; end
      2'd2:    begin pa_c = item_r.coord_z; pb_c = rd_r.z; end
      default: begin pa_c = {1'b0, mind_r}; pb_c = '0;     end
    endcase
    dif_c = {pa_c[31], pa_c} - {pb_c[31], pb_c};
    neg_c = -dif_c;
    if (mcnt_r == 2'd3) mag_c = pa_c;
    else if (dif_c[32]) mag_c = neg_c[31:0];
    else mag_c = dif_c[31:0];
  end

  always_comb begin
    eff_c = eff_of(cap_r);
    if (held_r >= eff_c) begin
      ev_c       = held_r - eff_c + CW'(1);
      held_tmp_c = eff_c - CW'(1);
    end else begin
      ev_c       = '0;
      held_tmp_c = held_r;
    end
    oldest_tmp_c = slot_add(oldest_r, ev_c);
  end

  always_comb begin
    age_sum_c = {1'b0, rd_r.age} + {1'b0, item_r.elapsed};
    age_new_c = age_sum_c[32] ? '1 : age_sum_c[31:0];
    left_c    = dur_r - ((rd_r.age < dur_r) ? rd_r.age : dur_r);
    cfg_eff_c = eff_of(cfg_wdata[CNT_W-1:0]);
  end

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    oldest_nxt    = oldest_r;
    cap_nxt       = cap_r;
    mind_nxt      = mind_r;
    dur_nxt       = dur_r;
    fade_nxt      = fade_r;
    alpha_nxt     = alpha_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mcnt_nxt      = mcnt_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    rd_cnt_nxt    = rd_cnt_r;
    rd_slot_nxt   = rd_slot_r;
    wr_slot_nxt   = wr_slot_r;
    pend_nxt      = pend_r;
    exp_nxt       = exp_r;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mul_a         = mag_c;
    mul_b         = mag_c;
    div_start     = 1'b0;

    // drop the output word once taken
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    // configuration writes; capacity trims the oldest points at once
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CAPACITY: begin
          cap_nxt = cfg_wdata[CNT_W-1:0];
          if (held_r > cfg_eff_c) begin
            oldest_nxt = slot_add(oldest_r, held_r - cfg_eff_c);
            held_nxt   = cfg_eff_c;
          end
        end
        CFG_MIN_DIST: mind_nxt  = cfg_wdata[30:0];
        CFG_DURATION: dur_nxt   = cfg_wdata;
        CFG_FADE:     fade_nxt  = cfg_wdata[0];
        CFG_ALPHA:    alpha_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt        = in_ch.data;
          res_nxt         = '0;
          res_nxt.status  = ST_DONE;
          mcnt_nxt        = '0;
          acc_nxt         = '0;
          case (opcode_t'(in_ch.data.opcode))
            OP_PUSH: begin
              if (held_r != '0 && mind_r != '0) begin
                // fetch the newest point for the spacing check
                mem_re    = 1'b1;
                mem_raddr = slot_add(oldest_r, held_r - CW'(1));
                state_nxt = S_MUL;
              end else begin
                state_nxt = S_PUSH_WR;
              end
            end
            OP_TICK: begin
              rd_cnt_nxt  = '0;
              rd_slot_nxt = oldest_r;
              wr_slot_nxt = oldest_r;
              pend_nxt    = 1'b0;
              exp_nxt     = '0;
              state_nxt   = S_TICK;
            end
            OP_CLEAR: begin
              held_nxt   = '0;
              oldest_nxt = '0;
              state_nxt  = S_FIN;
            end
            default: begin
              if (32'(in_ch.data.point_index) >= 32'(held_r)) begin
                res_nxt.status = ST_RANGE;
                state_nxt      = S_FIN;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot_add(oldest_r, CW'(in_ch.data.point_index));
                state_nxt = S_ALPHA_MUL;
              end
            end
          endcase
        end
      end

      S_MUL: begin
        // square one delta a cycle, accumulate the previous square
        prod_nxt = mul_p;
        if (mcnt_r != 2'd0) acc_nxt = sat_add(acc_r, prod_r);
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) state_nxt = S_CMP;
      end

      S_CMP: begin
        if (acc_r < prod_r) begin
          res_nxt.status = ST_TOO_CLOSE;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_PUSH_WR;
        end
      end

      S_PUSH_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = slot_add(oldest_tmp_c, held_tmp_c);
        mem_wdata.x     = item_r.coord_x;
        mem_wdata.y     = item_r.coord_y;
        mem_wdata.z     = item_r.coord_z;
        mem_wdata.age   = '0;
        oldest_nxt      = oldest_tmp_c;
        held_nxt        = held_tmp_c + CW'(1);
        res_nxt.removed = CNT_W'(ev_c);
        state_nxt       = S_FIN;
      end

      S_TICK: begin
        // read ahead, write back the entry read last cycle
        if (rd_cnt_r < held_r) begin
          mem_re      = 1'b1;
          mem_raddr   = rd_slot_r;
          rd_slot_nxt = slot_add(rd_slot_r, CW'(1));
          rd_cnt_nxt  = rd_cnt_r + CW'(1);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          mem_we        = 1'b1;
          mem_waddr     = wr_slot_r;
          mem_wdata     = rd_r;
          mem_wdata.age = age_new_c;
          wr_slot_nxt   = slot_add(wr_slot_r, CW'(1));
          // ages fall from oldest to newest, so expired points form a prefix
          if (dur_r != '0 && age_new_c > dur_r) exp_nxt = exp_r + CW'(1);
        end
        if (rd_cnt_r == held_r && !pend_r) begin
          held_nxt        = held_r - exp_r;
          oldest_nxt      = slot_add(oldest_r, exp_r);
          res_nxt.removed = CNT_W'(exp_r);
          state_nxt       = S_FIN;
        end
      end

      S_ALPHA_MUL: begin
        res_nxt.out_x     = rd_r.x;
        res_nxt.out_y     = rd_r.y;
        res_nxt.out_z     = rd_r.z;
        res_nxt.out_age   = rd_r.age;
        res_nxt.out_alpha = alpha_r;
        mul_a             = 32'(alpha_r);
        mul_b             = left_c;
        prod_nxt          = mul_p;
        if (fade_r && dur_r != '0) state_nxt = S_DIV_GO;
        else state_nxt = S_FIN;
      end

      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          res_nxt.out_alpha = div_quot;
          state_nxt         = S_FIN;
        end
      end

      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_nxt             = res_r;
          out_nxt.point_count = CNT_W'(held_r);
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  mtpb_alpha_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r[39:0]),
    .den   (dur_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      oldest_r    <= '0;
      cap_r       <= CNT_W'(64);
      mind_r      <= '0;
      dur_r       <= '0;
      fade_r      <= 1'b0;
      alpha_r     <= 8'hFF;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
      rd_cnt_r    <= '0;
      rd_slot_r   <= '0;
      wr_slot_r   <= '0;
      pend_r      <= 1'b0;
      exp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      oldest_r    <= oldest_nxt;
      cap_r       <= cap_nxt;
      mind_r      <= mind_nxt;
      dur_r       <= dur_nxt;
      fade_r      <= fade_nxt;
      alpha_r     <= alpha_nxt;
      out_valid_r <= out_valid_nxt;
      mcnt_r      <= mcnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rd_slot_r   <= rd_slot_nxt;
      wr_slot_r   <= wr_slot_nxt;
      pend_r      <= pend_nxt;
      exp_r       <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
endmodule

/* sv/mtpb_checker.sv */
// ----------------------------------------------------------------------------
// Motion trail point buffer checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "motion_trail_point_buffer_top_macros.svh"

module mtpb_checker #(
  parameter int MAX_POINTS = mtpb_pkg::MAX_POINTS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [mtpb_pkg::CNT_W-1:0] out_count,
  input logic [31:0]                out_age,
  input logic [7:0]                 out_alpha
);
  import mtpb_pkg::*;

  `MTPB_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result word after reset")
  `MTPB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped")
  `MTPB_ASSERT(a_one_at_time, in_valid && in_ready |=> !in_ready, "second word taken early")
  `MTPB_ASSERT(a_range_zero, out_valid && out_status == ST_RANGE |-> out_age == '0 && out_alpha == '0 && 32'(out_count) <= 32'(MAX_POINTS), "bad out-of-range word")
endmodule

bind motion_trail_point_buffer_top mtpb_checker #(.MAX_POINTS(MAX_POINTS)) u_mtpb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.data.status),
  .out_count  (out_ch.data.point_count),
  .out_age    (out_ch.data.out_age),
  .out_alpha  (out_ch.data.out_alpha)
);
